### design/msc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, constants and small decode functions of the minutes:seconds
// clock: register map, display codes and seven-segment patterns.
// ----------------------------------------------------------------------------
package msc_pkg;

    // Configuration register map (byte addresses, 4 bytes apart).
    localparam int unsigned AddrWidth = 3;
    localparam logic RegShortReload = 1'b0;
    localparam logic RegLongReload  = 1'b1;

    // Reset values of the configuration and the time.
    localparam logic [15:0] ShortReloadReset = 16'd200;
    localparam logic [15:0] LongReloadReset  = 16'd1000;
    localparam logic [5:0]  TimeReset        = 6'd58;
    localparam logic [6:0]  WrapLimit        = 7'd60;

    // Display scan places.
    localparam logic [2:0] PlaceMinTens = 3'd0;
    localparam logic [2:0] PlaceMinOnes = 3'd1;
    localparam logic [2:0] PlaceDash    = 3'd2;
    localparam logic [2:0] PlaceSecTens = 3'd3;
    localparam logic [2:0] PlaceSecOnes = 3'd4;

    // Place selects and the dash pattern.
    localparam logic [4:0] SelMinTens = 5'h01;
    localparam logic [4:0] SelMinOnes = 5'h02;
    localparam logic [4:0] SelDash    = 5'h04;
    localparam logic [4:0] SelSecTens = 5'h08;
    localparam logic [4:0] SelSecOnes = 5'h10;
    localparam logic [7:0] DashPattern = 8'h40;

    // Divider flags handed from the time base to the time keeper.
    typedef struct packed {
        logic short_flag;
        logic long_flag;
    } t_flags;

    // What the display scanner drives in one pass.
    typedef struct packed {
        logic [7:0] segments;
        logic [4:0] digit_select;
        logic       display_valid;
    } t_disp;

    // One result item.
    typedef struct packed {
        logic [5:0] minutes;
        logic [5:0] seconds;
        t_disp      disp;
    } t_result;

    // Seven-segment pattern of a decimal digit, bit 0 is segment a.
    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3f;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5b;
            4'd3:    p = 8'h4f;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6d;
            4'd6:    p = 8'h7d;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7f;
            4'd9:    p = 8'h6f;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // Tens digit of a value below 60, by a row of compares.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd50)      t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // Ones digit of a value below 60.
    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] tens_x10;
        logic [5:0] rem;
        tens_x10 = {2'b00, tens_of(v)} * 6'd10;
        rem      = v - tens_x10;
        return rem[3:0];
    endfunction

endpackage

### design/minute_second_clock_with_set_keys.sv
`timescale 1ns / 1ps
// An accepted request's result is registered in the output register or the skid.
// One request per cycle when not stalled; all state updates on acceptance.
// A two-entry output stage (result register plus skid) lets input run while
// the result side stalls; the input stalls only when both entries are full.
// Reset (synchronous, active low) sets the time to 58:58, clears dividers,
// flags, key state and scan position, and loads reloads of 200 and 1000.
// ----------------------------------------------------------------------------
// minute_second_clock_with_set_keys
// Minutes:seconds clock with two set keys and a five-place scanned display.
// ----------------------------------------------------------------------------
module minute_second_clock_with_set_keys
    import msc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  logic                 i_key_one_down,
    input  logic                 i_key_two_down,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [5:0]           o_minutes,
    output logic [5:0]           o_seconds,
    output logic [7:0]           o_segments,
    output logic [4:0]           o_digit_select,
    output logic                 o_display_valid,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic        in_take, out_take;
    logic        tick, pass;
    logic [15:0] short_reload, long_reload;
    t_flags      flags;
    logic [5:0]  minutes_cur, seconds_cur, minutes_next, seconds_next;
    t_disp       disp;
    t_result     new_result;
    t_result     r_out, n_out;
    t_result     r_skid, n_skid;
    logic        r_out_valid, n_out_valid;
    logic        r_skid_valid, n_skid_valid;

    // Request handshakes.
    assign o_stall  = r_skid_valid;
    assign in_take  = i_valid & ~r_skid_valid;
    assign out_take = r_out_valid & ~i_stall;
    assign tick     = in_take & ~i_mode;
    assign pass     = in_take & i_mode;

    msc_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_short_reload (short_reload),
        .o_long_reload  (long_reload)
    );

    msc_timebase u_timebase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_pass         (pass),
        .i_short_reload (short_reload),
        .i_long_reload  (long_reload),
        .o_flags        (flags)
    );

    msc_time u_time (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pass         (pass),
        .i_key_one      (i_key_one_down),
        .i_key_two      (i_key_two_down),
        .i_flags        (flags),
        .o_minutes_cur  (minutes_cur),
        .o_seconds_cur  (seconds_cur),
        .o_minutes_next (minutes_next),
        .o_seconds_next (seconds_next)
    );

    msc_display u_display (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pass    (pass),
        .i_minutes (minutes_cur),
        .i_seconds (seconds_cur),
        .o_disp    (disp)
    );

    // Result of the request taken this cycle.
    assign new_result.minutes = minutes_next;
    assign new_result.seconds = seconds_next;
    assign new_result.disp    = disp;

    // Output register with a skid entry behind it.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = new_result;
                n_out_valid = in_take;
            end
        end else if (in_take) begin
            n_skid       = new_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid         = r_out_valid;
    assign o_minutes       = r_out.minutes;
    assign o_seconds       = r_out.seconds;
    assign o_segments      = r_out.disp.segments;
    assign o_digit_select  = r_out.disp.digit_select;
    assign o_display_valid = r_out.disp.display_valid;

endmodule

### design/msc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_cfg
// APB-style register file holding the two divider reload values.
// ----------------------------------------------------------------------------
module msc_cfg
    import msc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic [15:0]          o_short_reload,
    output logic [15:0]          o_long_reload
);

    logic [15:0] r_short_reload;
    logic [15:0] r_long_reload;
    logic        wr_req;
    logic        reg_sel;

    // The register index sits in bit 2 of the byte address.
    assign reg_sel = paddr[2];
    assign wr_req  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_reload <= ShortReloadReset;
            r_long_reload  <= LongReloadReset;
        end else if (wr_req) begin
            if (reg_sel == RegShortReload) begin
                r_short_reload <= pwdata[15:0];
            end else begin
                r_long_reload <= pwdata[15:0];
            end
        end
    end

    // Read back.
    always_comb begin
        if (reg_sel == RegShortReload) begin
            prdata = {16'h0000, r_short_reload};
        end else begin
            prdata = {16'h0000, r_long_reload};
        end
    end

    assign o_short_reload = r_short_reload;
    assign o_long_reload  = r_long_reload;

endmodule

### design/msc_timebase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_timebase
// Two reload-when-zero down counters. Each raises its flag when it reaches
// zero on a tick; a loop pass consumes both flags.
// ----------------------------------------------------------------------------
module msc_timebase
    import msc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick,
    input  logic        i_pass,
    input  logic [15:0] i_short_reload,
    input  logic [15:0] i_long_reload,
    output t_flags      o_flags
);

    logic [15:0] r_short_count, n_short_count;
    logic [15:0] r_long_count,  n_long_count;
    t_flags      r_flags, n_flags;

    // Next counter and flag values.
    always_comb begin
        n_short_count = r_short_count;
        n_long_count  = r_long_count;
        n_flags       = r_flags;
        if (i_tick) begin
            if (r_short_count == 16'd0) begin
                n_short_count      = i_short_reload;
                n_flags.short_flag = 1'b1;
            end else begin
                n_short_count = r_short_count - 16'd1;
            end
            if (r_long_count == 16'd0) begin
                n_long_count      = i_long_reload;
                n_flags.long_flag = 1'b1;
            end else begin
                n_long_count = r_long_count - 16'd1;
            end
        end else if (i_pass) begin
            n_flags = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_count <= '0;
            r_long_count  <= '0;
            r_flags       <= '0;
        end else begin
            r_short_count <= n_short_count;
            r_long_count  <= n_long_count;
            r_flags       <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

### design/msc_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_display
// Five-place display scanner. The first place takes a snapshot of the time
// as four digits; later places show the stored digits.
// ----------------------------------------------------------------------------
module msc_display
    import msc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pass,
    input  logic [5:0] i_minutes,
    input  logic [5:0] i_seconds,
    output t_disp      o_disp
);

    logic [2:0] r_place, n_place;
    logic [3:0] r_dig_min_ones, n_dig_min_ones;
    logic [3:0] r_dig_sec_tens, n_dig_sec_tens;
    logic [3:0] r_dig_sec_ones, n_dig_sec_ones;

    // Place decode and snapshot.
    always_comb begin
        n_place        = r_place;
        n_dig_min_ones = r_dig_min_ones;
        n_dig_sec_tens = r_dig_sec_tens;
        n_dig_sec_ones = r_dig_sec_ones;
        o_disp         = '0;
        if (i_pass) begin
            o_disp.display_valid = 1'b1;
            case (r_place)
                PlaceMinOnes: begin
                    o_disp.segments     = seg_pattern(r_dig_min_ones);
                    o_disp.digit_select = SelMinOnes;
                    n_place             = PlaceDash;
                end
                PlaceDash: begin
                    o_disp.segments     = DashPattern;
                    o_disp.digit_select = SelDash;
                    n_place             = PlaceSecTens;
                end
                PlaceSecTens: begin
                    o_disp.segments     = seg_pattern(r_dig_sec_tens);
                    o_disp.digit_select = SelSecTens;
                    n_place             = PlaceSecOnes;
                end
                PlaceSecOnes: begin
                    o_disp.segments     = seg_pattern(r_dig_sec_ones);
                    o_disp.digit_select = SelSecOnes;
                    n_place             = PlaceMinTens;
                end
                default: begin
                    // Restart: show minute tens and keep the other digits.
                    o_disp.segments     = seg_pattern(tens_of(i_minutes));
                    o_disp.digit_select = SelMinTens;
                    n_dig_min_ones      = ones_of(i_minutes);
                    n_dig_sec_tens      = tens_of(i_seconds);
                    n_dig_sec_ones      = ones_of(i_seconds);
                    n_place             = PlaceMinOnes;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place <= PlaceMinTens;
        end else begin
            r_place <= n_place;
        end
    end

    // Snapshot digits need no reset: they are loaded before they are shown.
    always_ff @(posedge i_clk) begin
        r_dig_min_ones <= n_dig_min_ones;
        r_dig_sec_tens <= n_dig_sec_tens;
        r_dig_sec_ones <= n_dig_sec_ones;
    end

endmodule

### design/msc_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_time
// Time keeper: minute and second counters, key hold tracking, seconds flag,
// auto-repeat while a key is held, step on release and wrap at sixty.
// ----------------------------------------------------------------------------
module msc_time
    import msc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pass,
    input  logic       i_key_one,
    input  logic       i_key_two,
    input  t_flags     i_flags,
    output logic [5:0] o_minutes_cur,
    output logic [5:0] o_seconds_cur,
    output logic [5:0] o_minutes_next,
    output logic [5:0] o_seconds_next
);

    logic [5:0] r_minutes, n_minutes;
    logic [5:0] r_seconds, n_seconds;
    logic       r_key_one_held, n_key_one_held;
    logic       r_key_two_held, n_key_two_held;
    logic       sec_by_flag, sec_by_repeat, sec_by_release;
    logic       min_by_repeat, min_by_release;
    logic [6:0] sec_sum, min_sum, min_carried;
    logic       sec_wrap;

    // Increment sources for this pass.
    assign sec_by_flag    = i_flags.long_flag & ~r_key_one_held & ~r_key_two_held;
    assign sec_by_repeat  = i_flags.short_flag & r_key_one_held;
    assign sec_by_release = r_key_one_held & ~i_key_one;
    assign min_by_repeat  = i_flags.short_flag & r_key_two_held;
    assign min_by_release = r_key_two_held & ~i_key_two;

    // Sums and wrap at sixty, seconds carrying one minute.
    assign sec_sum     = 7'(r_seconds) + 7'(sec_by_flag) + 7'(sec_by_repeat)
                       + 7'(sec_by_release);
    assign min_sum     = 7'(r_minutes) + 7'(min_by_repeat) + 7'(min_by_release);
    assign sec_wrap    = sec_sum >= WrapLimit;
    assign min_carried = min_sum + 7'(sec_wrap);

    always_comb begin
        n_minutes      = r_minutes;
        n_seconds      = r_seconds;
        n_key_one_held = r_key_one_held;
        n_key_two_held = r_key_two_held;
        if (i_pass) begin
            n_seconds      = sec_wrap ? 6'd0 : sec_sum[5:0];
            n_minutes      = (min_carried >= WrapLimit) ? 6'd0 : min_carried[5:0];
            n_key_one_held = i_key_one;
            n_key_two_held = i_key_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minutes      <= TimeReset;
            r_seconds      <= TimeReset;
            r_key_one_held <= 1'b0;
            r_key_two_held <= 1'b0;
        end else begin
            r_minutes      <= n_minutes;
            r_seconds      <= n_seconds;
            r_key_one_held <= n_key_one_held;
            r_key_two_held <= n_key_two_held;
        end
    end

    assign o_minutes_cur  = r_minutes;
    assign o_seconds_cur  = r_seconds;
    assign o_minutes_next = n_minutes;
    assign o_seconds_next = n_seconds;

endmodule

### verif/minute_second_clock_with_set_keys_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minute_second_clock_with_set_keys_tb
// Drives timer ticks and key-sampling loop passes into the minutes:seconds
// clock and predicts each result: time, scanned display place and pattern.
// Every result is compared field by field with the prediction. The reloads
// are changed between phases over APB, and both request and result sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module minute_second_clock_with_set_keys_tb;
    import msc_pkg::*;

    localparam logic ModeTick = 1'b0;
    localparam logic ModePass = 1'b1;
    localparam logic [7:0] DigitSegments [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct {
        logic mode;
        logic key_one;
        logic key_two;
    } t_clock_request;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_mode = 1'b0;
    logic                 i_key_one_down = 1'b0;
    logic                 i_key_two_down = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [5:0]           o_minutes;
    logic [5:0]           o_seconds;
    logic [7:0]           o_segments;
    logic [4:0]           o_digit_select;
    logic                 o_display_valid;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Requests waiting to be driven and results still to come.
    t_clock_request pending_requests[$];
    t_result        expected_results[$];
    t_clock_request next_request;
    t_result        predicted;

    // Own copy of the clock state and its reloads.
    logic [15:0] short_reload = ShortReloadReset;
    logic [15:0] long_reload  = LongReloadReset;
    logic [15:0] short_count  = '0;
    logic [15:0] long_count   = '0;
    logic        repeat_flag  = 1'b0;
    logic        second_flag  = 1'b0;
    logic [5:0]  minute_now   = TimeReset;
    logic [5:0]  second_now   = TimeReset;
    logic        key_one_held = 1'b0;
    logic        key_two_held = 1'b0;
    logic [2:0]  scan_place   = PlaceMinTens;
    logic [12:0] shown_value  = '0;

    logic key_one_level = 1'b0;
    logic key_two_level = 1'b0;
    logic steady        = 1'b0;
    logic req_taken     = 1'b0;
    int   error_count   = 0;

    minute_second_clock_with_set_keys uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_key_one_down  (i_key_one_down),
        .i_key_two_down  (i_key_two_down),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_minutes       (o_minutes),
        .o_seconds       (o_seconds),
        .o_segments      (o_segments),
        .o_digit_select  (o_digit_select),
        .o_display_valid (o_display_valid),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] digit_segments(input int unsigned d);
        return (d < 10) ? DigitSegments[d] : 8'h00;
    endfunction

    // Advance the clock state by one request and return the expected result.
    task automatic advance_clock(input logic mode, input logic k1, input logic k2,
                                 output t_result r);
        int unsigned mn;
        int unsigned sc;
        r = '0;
        if (mode == ModeTick) begin
            // Both dividers reload at zero and raise their flag.
            if (short_count == 0) begin
                short_count = short_reload;
                repeat_flag = 1'b1;
            end else begin
                short_count = short_count - 16'd1;
            end
            if (long_count == 0) begin
                long_count  = long_reload;
                second_flag = 1'b1;
            end else begin
                long_count = long_count - 16'd1;
            end
        end else begin
            mn = minute_now;
            sc = second_now;
            r.disp.display_valid = 1'b1;
            // Drive the next display place; a restart takes a fresh snapshot.
            case (scan_place)
                PlaceMinOnes: begin
                    r.disp.segments     = digit_segments(shown_value / 100);
                    r.disp.digit_select = SelMinOnes;
                    shown_value         = shown_value % 13'd100;
                    scan_place          = PlaceDash;
                end
                PlaceDash: begin
                    r.disp.segments     = DashPattern;
                    r.disp.digit_select = SelDash;
                    scan_place          = PlaceSecTens;
                end
                PlaceSecTens: begin
                    r.disp.segments     = digit_segments(shown_value / 10);
                    r.disp.digit_select = SelSecTens;
                    shown_value         = shown_value % 13'd10;
                    scan_place          = PlaceSecOnes;
                end
                PlaceSecOnes: begin
                    r.disp.segments     = digit_segments(shown_value);
                    r.disp.digit_select = SelSecOnes;
                    shown_value         = '0;
                    scan_place          = PlaceMinTens;
                end
                default: begin
                    shown_value         = 13'(mn * 100 + sc);
                    r.disp.segments     = digit_segments(shown_value / 1000);
                    r.disp.digit_select = SelMinTens;
                    shown_value         = shown_value % 13'd1000;
                    scan_place          = PlaceMinOnes;
                end
            endcase
            // The seconds flag counts only while no key is held.
            if (second_flag) begin
                second_flag = 1'b0;
                if (!key_one_held && !key_two_held) sc++;
            end
            // The repeat flag steps whatever is held.
            if (repeat_flag) begin
                repeat_flag = 1'b0;
                if (key_one_held) sc++;
                if (key_two_held) mn++;
            end
            // A release adds one step.
            if (!k1 && key_one_held) sc++;
            key_one_held = k1;
            if (!k2 && key_two_held) mn++;
            key_two_held = k2;
            if (sc >= 60) begin
                mn++;
                sc = 0;
            end
            if (mn >= 60) mn = 0;
            minute_now = 6'(mn);
            second_now = 6'(sc);
        end
        r.minutes = minute_now;
        r.seconds = second_now;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Driver: a new request goes out at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= !steady && ($urandom_range(0, 99) < 21);
            if (!i_valid || req_taken) begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 21))
                begin
                    next_request = pending_requests.pop_front();
                    i_mode         <= next_request.mode;
                    i_key_one_down <= next_request.key_one;
                    i_key_two_down <= next_request.key_two;
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, track register writes and predict accepted requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %0d:%0d", $time,
                             o_minutes, o_seconds);
                    error_count++;
                end else begin
                    predicted = expected_results.pop_front();
                    compare_field("minutes", predicted.minutes, o_minutes);
                    compare_field("seconds", predicted.seconds, o_seconds);
                    compare_field("segments", predicted.disp.segments, o_segments);
                    compare_field("digit_select", predicted.disp.digit_select,
                                  o_digit_select);
                    compare_field("display_valid", predicted.disp.display_valid,
                                  o_display_valid);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == RegShortReload) short_reload = pwdata[15:0];
                else long_reload = pwdata[15:0];
            end
            req_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                advance_clock(i_mode, i_key_one_down, i_key_two_down, predicted);
                expected_results.push_back(predicted);
            end
        end
    end

    task automatic queue_request(input logic mode, input logic k1, input logic k2);
        t_clock_request r;
        r.mode    = mode;
        r.key_one = k1;
        r.key_two = k2;
        pending_requests.push_back(r);
    endtask

    // Mostly clean key presses with random timing, some bounce noise on top.
    task automatic queue_random(input int count);
        t_clock_request r;
        for (int n = 0; n < count; n++) begin
            r.mode = ($urandom_range(0, 99) < 55) ? ModeTick : ModePass;
            if (r.mode == ModePass) begin
                if ($urandom_range(0, 99) < 12) key_one_level = !key_one_level;
                if ($urandom_range(0, 99) < 9) key_two_level = !key_two_level;
                r.key_one = key_one_level;
                r.key_two = key_two_level;
                if ($urandom_range(0, 99) < 5) begin
                    r.key_one = 1'($urandom_range(0, 1));
                    r.key_two = 1'($urandom_range(0, 1));
                end
            end else begin
                r.key_one = 1'($urandom_range(0, 1));
                r.key_two = 1'($urandom_range(0, 1));
            end
            pending_requests.push_back(r);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    task automatic write_reload(input logic index, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_reloads(input logic [15:0] short_value, input logic [15:0] long_value);
        wait_drained();
        write_reload(RegShortReload, short_value);
        write_reload(RegLongReload, long_value);
    endtask

    // Stimulus phases.
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Loop passes only at reset reloads: scan wrap, releases and both overflows.
        queue_request(ModePass, 1'b0, 1'b0);
        queue_request(ModePass, 1'b1, 1'b0);
        queue_request(ModePass, 1'b0, 1'b0);
        queue_request(ModePass, 1'b0, 1'b0);
        queue_request(ModePass, 1'b0, 1'b0);
        queue_request(ModePass, 1'b1, 1'b0);
        queue_request(ModePass, 1'b0, 1'b0);
        queue_request(ModePass, 1'b0, 1'b1);
        queue_request(ModePass, 1'b0, 1'b0);
        queue_request(ModePass, 1'b1, 1'b1);
        queue_request(ModePass, 1'b0, 1'b0);

        // Reloads of one: ignored keys on ticks, seconds flag and key repeat.
        set_reloads(16'd1, 16'd1);
        queue_request(ModeTick, 1'b1, 1'b1);
        queue_request(ModePass, 1'b1, 1'b0);
        queue_request(ModeTick, 1'b0, 1'b0);
        queue_request(ModeTick, 1'b0, 1'b0);
        queue_request(ModePass, 1'b1, 1'b0);
        queue_request(ModeTick, 1'b0, 1'b1);
        queue_request(ModeTick, 1'b1, 1'b0);
        queue_request(ModePass, 1'b1, 1'b1);
        queue_request(ModeTick, 1'b0, 1'b0);
        queue_request(ModeTick, 1'b0, 1'b0);
        queue_request(ModePass, 1'b1, 1'b1);
        queue_request(ModePass, 1'b0, 1'b0);
        queue_random(150);

        // Here the sender also holds off halfway until the clock has caught up.
        set_reloads(16'd3, 16'd1);
        queue_random(75);
        wait_drained();
        queue_random(75);

        // A long stretch with neither side idling.
        set_reloads(16'($urandom_range(1, 5)), 16'($urandom_range(2, 9)));
        wait_drained();
        steady = 1'b1;
        queue_random(200);
        wait_drained();
        steady = 1'b0;

        set_reloads(16'd7, 16'd11);
        queue_random(150);

        set_reloads(16'd65535, 16'd1);
        queue_random(120);

        set_reloads(16'd1, 16'd65535);
        queue_random(130);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("minute_second_clock_with_set_keys_tb: clean");
        end else begin
            $display("minute_second_clock_with_set_keys_tb: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("minute_second_clock_with_set_keys_tb: errors");
        $finish;
    end

endmodule
